FILE: design/box_clip_space_cull_test_unit_macros.svh
// assertion macros for the clip-space cull test unit
`ifndef BOX_CLIP_SPACE_CULL_TEST_UNIT_MACROS_SVH
`define BOX_CLIP_SPACE_CULL_TEST_UNIT_MACROS_SVH

// implication checked every clock edge outside reset
`define BCC_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define BCC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

FILE: design/bccull_pkg.sv
// ---------------------------------------------------------------------------
// bccull_pkg
// shared types and widths for the clip-space cull test unit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bccull_pkg;

    localparam int unsigned CoordW = 32;
    localparam int unsigned ProdW  = 64;
    localparam int unsigned AccW   = 68;
    localparam int unsigned InW    = 512;

    typedef logic signed [CoordW-1:0] t_coord;
    typedef logic signed [ProdW-1:0]  t_prod;
    typedef logic signed [AccW-1:0]   t_acc;

    // products of one matrix row: x, y, width, height terms and translation
    typedef struct packed {
        t_prod px;
        t_prod py;
        t_prod pw;
        t_prod ph;
        t_prod pt;
    } t_row_prod;

    // clip coordinates of the translation point and four corners, rows 0..3
    typedef struct packed {
        t_acc [3:0] t;
        t_acc [3:0] c0;
        t_acc [3:0] c1;
        t_acc [3:0] c2;
        t_acc [3:0] c3;
    } t_clip_pts;

    // plane test flags: lo and hi per row 0..2
    typedef struct packed {
        logic [2:0] lo;
        logic [2:0] hi;
    } t_plane_flags;

    function automatic t_acc sext_prod(input t_prod p);
        sext_prod = {{(AccW-ProdW){p[ProdW-1]}}, p};
    endfunction

endpackage

FILE: design/bccull_mul.sv
// ---------------------------------------------------------------------------
// bccull_mul
// product stage: all matrix-by-box products for the four rows
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bccull_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [bccull_pkg::InW-1:0]  i_data,
    output logic                        o_valid,
    output bccull_pkg::t_row_prod [3:0] o_prod
);

    bccull_pkg::t_coord bx, by, bw, bh;
    bccull_pkg::t_coord m0 [4];
    bccull_pkg::t_coord m1 [4];
    bccull_pkg::t_coord m3 [4];
    bccull_pkg::t_row_prod [3:0] n_prod;
    bccull_pkg::t_row_prod [3:0] r_prod;
    logic r_valid;

    assign bx = i_data[31:0];
    assign by = i_data[63:32];
    assign bw = i_data[95:64];
    assign bh = i_data[127:96];

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            m0[r] = i_data[128 + 32*r +: 32];
            m1[r] = i_data[256 + 32*r +: 32];
            m3[r] = i_data[384 + 32*r +: 32];
            n_prod[r].px = bccull_pkg::t_prod'(m0[r]) * bccull_pkg::t_prod'(bx);
            n_prod[r].py = bccull_pkg::t_prod'(m1[r]) * bccull_pkg::t_prod'(by);
            n_prod[r].pw = bccull_pkg::t_prod'(m0[r]) * bccull_pkg::t_prod'(bw);
            n_prod[r].ph = bccull_pkg::t_prod'(m1[r]) * bccull_pkg::t_prod'(bh);
            n_prod[r].pt = {{16{m3[r][31]}}, m3[r], 16'h0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;

endmodule

FILE: design/bccull_sum.sv
// ---------------------------------------------------------------------------
// bccull_sum
// accumulate stage: clip coordinates of translation and of the four corners
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bccull_sum (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  bccull_pkg::t_row_prod [3:0] i_prod,
    output logic                        o_valid,
    output bccull_pkg::t_clip_pts       o_pts
);

    bccull_pkg::t_clip_pts n_pts, r_pts;
    bccull_pkg::t_acc base;
    logic r_valid;

    always_comb begin
        n_pts = '0;
        base  = '0;
        for (int r = 0; r < 4; r++) begin
            base = bccull_pkg::sext_prod(i_prod[r].pt) + bccull_pkg::sext_prod(i_prod[r].px)
                 + bccull_pkg::sext_prod(i_prod[r].py);
            n_pts.t[r]  = bccull_pkg::sext_prod(i_prod[r].pt);
            n_pts.c0[r] = base;
            n_pts.c1[r] = base + bccull_pkg::sext_prod(i_prod[r].pw);
            n_pts.c2[r] = base + bccull_pkg::sext_prod(i_prod[r].ph);
            n_pts.c3[r] = base + bccull_pkg::sext_prod(i_prod[r].pw)
                        + bccull_pkg::sext_prod(i_prod[r].ph);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pts <= n_pts;
        end
    end

    assign o_valid = r_valid;
    assign o_pts   = r_pts;

endmodule

FILE: design/bccull_plane.sv
// ---------------------------------------------------------------------------
// bccull_plane
// plane stage: w + c and w - c sign tests for every point
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bccull_plane (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  bccull_pkg::t_clip_pts          i_pts,
    output logic                           o_valid,
    output bccull_pkg::t_plane_flags [4:0] o_flags
);

    bccull_pkg::t_plane_flags [4:0] n_flags, r_flags;
    bccull_pkg::t_acc [3:0] pt [5];
    bccull_pkg::t_acc s;
    logic r_valid;

    always_comb begin
        pt[0] = i_pts.t;
        pt[1] = i_pts.c0;
        pt[2] = i_pts.c1;
        pt[3] = i_pts.c2;
        pt[4] = i_pts.c3;
        n_flags = '0;
        s = '0;
        for (int p = 0; p < 5; p++) begin
            for (int r = 0; r < 3; r++) begin
                s = pt[p][3] + pt[p][r];
                n_flags[p].lo[r] = ~s[bccull_pkg::AccW-1];
                s = pt[p][3] - pt[p][r];
                n_flags[p].hi[r] = ~s[bccull_pkg::AccW-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flags <= n_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_flags = r_flags;

endmodule

FILE: design/box_clip_space_cull_test_unit.sv
// ---------------------------------------------------------------------------
// box_clip_space_cull_test_unit
// decides whether a 2d box at z = 0 falls outside clip space
// ---------------------------------------------------------------------------
// One box per clock cycle is accepted unless the output stalls; each verdict
// passes the product, sum, plane and decision registers once its box is taken.
// The pipeline advances whenever the output register is empty or being
// drained, so a stalled output holds every stage and nothing is lost.
`timescale 1ns / 1ps

module box_clip_space_cull_test_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // box_x, box_y, box_width, box_height, mat_col0_rows01, mat_col0_rows23,
    // mat_col1_rows01, mat_col1_rows23, mat_col3_rows01, mat_col3_rows23
    input  logic [511:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // is_outside, zero padded
    output logic [7:0]   m_axis_tdata
);

    logic en;
    logic v1, v2, v3;
    bccull_pkg::t_row_prod [3:0] prod;
    bccull_pkg::t_clip_pts pts;
    bccull_pkg::t_plane_flags [4:0] flags;
    logic n_out;
    logic r_valid, r_out;
    logic [3:0] cnt_ok;

    assign en = !r_valid || m_axis_tready;
    assign s_axis_tready = en;

    bccull_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(s_axis_tvalid),
        .i_data(s_axis_tdata), .o_valid(v1), .o_prod(prod)
    );

    bccull_sum u_sum (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(v1),
        .i_prod(prod), .o_valid(v2), .o_pts(pts)
    );

    bccull_plane u_plane (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(v2),
        .i_pts(pts), .o_valid(v3), .o_flags(flags)
    );

    always_comb begin
        logic any_in;
        any_in = 1'b0;
        for (int p = 0; p < 5; p++) begin
            any_in = any_in | (&flags[p].lo & &flags[p].hi);
        end
        cnt_ok[0] = flags[1].lo[0] | flags[2].lo[0] | flags[3].lo[0] | flags[4].lo[0];
        cnt_ok[1] = flags[1].hi[0] | flags[2].hi[0] | flags[3].hi[0] | flags[4].hi[0];
        cnt_ok[2] = flags[1].lo[1] | flags[2].lo[1] | flags[3].lo[1] | flags[4].lo[1];
        cnt_ok[3] = flags[1].hi[1] | flags[2].hi[1] | flags[3].hi[1] | flags[4].hi[1];
        if (any_in) begin
            n_out = 1'b0;
        end else if (cnt_ok != 4'hf) begin
            n_out = 1'b1;
        end else begin
            n_out = (flags[1].lo[0] & flags[2].lo[0] & flags[3].lo[0] & flags[4].lo[0])
                  & (flags[1].hi[0] & flags[2].hi[0] & flags[3].hi[0] & flags[4].hi[0])
                  & (flags[1].lo[1] & flags[2].lo[1] & flags[3].lo[1] & flags[4].lo[1])
                  & (flags[1].hi[1] & flags[2].hi[1] & flags[3].hi[1] & flags[4].hi[1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {7'b0, r_out};

endmodule

FILE: design/bccull_checker.sv
// ---------------------------------------------------------------------------
// bccull_checker
// port-level checks on the clip-space cull test unit
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "box_clip_space_cull_test_unit_macros.svh"

module bccull_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [7:0]   m_axis_tdata
);

    `BCC_ASSERT_IMPL(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[7:1] == 7'b0)
    `BCC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
    `BCC_ASSERT_IMPL(a_ready_free, i_clk, i_rst_n, !m_axis_tvalid || m_axis_tready,
        s_axis_tready)
    `BCC_ASSERT_IMPL(a_ready_stall, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        !s_axis_tready)

endmodule

bind box_clip_space_cull_test_unit bccull_checker u_bccull_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

FILE: tb/box_clip_space_cull_test_unit_tb.sv
// ---------------------------------------------------------------------------
// box_clip_space_cull_test_unit_tb
// drives boxes and matrices through the cull unit and checks each verdict
// against an exact wide-integer clip-space predictor, under random idling
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_clip_space_cull_test_unit_tb;

    localparam int NumRandom = 1000;
    localparam int WatchLimit = 5000;
    localparam int Latency = 4;

    typedef logic signed [95:0] t_wide;

    typedef struct {
        logic [31:0] bx, by, bw, bh;
        logic [63:0] c0a, c0b, c1a, c1b, c3a, c3b;
        int          verdict;
    } t_box_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [511:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [7:0]   m_axis_tdata;

    logic         verdict_q[$];
    int           n_errors = 0;
    int           idle_cycles = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    bit           hold_off = 1'b0;

    box_clip_space_cull_test_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_wide widen(input logic [31:0] v);
        widen = {{64{v[31]}}, v};
    endfunction

    function automatic bit in_clip_cube(input t_wide p[4]);
        bit ok;
        ok = 1'b1;
        for (int r = 0; r < 3; r++) begin
            if ((p[3] + p[r]) < 0 || (p[3] - p[r]) < 0) ok = 1'b0;
        end
        in_clip_cube = ok;
    endfunction

    function automatic logic cull_verdict(input logic [511:0] d);
        t_wide m[3][4];
        t_wide t[4];
        t_wide v[4][4];
        t_wide p[4];
        t_wide bx, by, bw, bh;
        int    cnt[4];
        bit    none, all;
        bx = widen(d[31:0]);
        by = widen(d[63:32]);
        bw = widen(d[95:64]);
        bh = widen(d[127:96]);
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 4; r++) begin
                m[c][r] = widen(d[128 + 128*c + 32*r +: 32]);
            end
        end
        for (int r = 0; r < 4; r++) t[r] = m[2][r] * 65536;
        if (in_clip_cube(t)) return 1'b0;
        for (int k = 0; k < 4; k++) begin
            for (int r = 0; r < 4; r++) begin
                v[k][r] = t[r] + m[0][r] * bx + m[1][r] * by;
                if (k[0]) v[k][r] += m[0][r] * bw;
                if (k[1]) v[k][r] += m[1][r] * bh;
                p[r] = v[k][r];
            end
            if (in_clip_cube(p)) return 1'b0;
        end
        cnt = '{0, 0, 0, 0};
        for (int k = 0; k < 4; k++) begin
            if (v[k][3] + v[k][0] >= 0) cnt[0]++;
            if (v[k][3] - v[k][0] >= 0) cnt[1]++;
            if (v[k][3] + v[k][1] >= 0) cnt[2]++;
            if (v[k][3] - v[k][1] >= 0) cnt[3]++;
        end
        none = 1'b0;
        all = 1'b1;
        for (int k = 0; k < 4; k++) begin
            if (cnt[k] == 0) none = 1'b1;
            if (cnt[k] < 4) all = 1'b0;
        end
        return none ? 1'b1 : all;
    endfunction

    task automatic report_mismatch(input string what, input logic got, input logic want);
        $display("mismatch: %s got %0b expected %0b at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    function automatic logic [511:0] pack_box(input t_box_row row);
        return {row.c3b, row.c3a, row.c1b, row.c1a, row.c0b, row.c0a,
                row.bh, row.bw, row.by, row.bx};
    endfunction

    // one transaction offered and held until taken
    task automatic send_box(input logic [511:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        verdict_q.push_back(cull_verdict(d));
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    function automatic logic [63:0] rand_pair();
        return {rand_coord(), rand_coord()};
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("unexpected verdict", m_axis_tdata[0], 1'b0);
                end else begin
                    logic want;
                    want = verdict_q.pop_front();
                    if (m_axis_tdata[0] !== want)
                        report_mismatch("is_outside", m_axis_tdata[0], want);
                    if (m_axis_tdata[7:1] !== 7'd0)
                        report_mismatch("padding", 1'b1, 1'b0);
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchLimit) begin
                $display("box_clip_space_cull_test_unit_tb: errors");
                $finish;
            end
        end
    end

    initial begin
        t_box_row rows[$];
        t_box_row row;
        int       pcts[4][2];
        localparam logic [31:0] One = 32'h0001_0000;
        pcts = '{'{0, 0}, '{69, 0}, '{0, 69}, '{35, 35}};
        // translation at origin, w = 1: inside
        rows.push_back('{0, 0, One, One, 0, 0, 0, 0, 0, {One, 32'd0}, 0});
        // w = 0 with every corner at the origin: boundary counts as inside
        rows.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        // translation far right, zero box: all corners fail the right plane
        rows.push_back('{0, 0, 0, 0, 0, 0, 0, 0, {32'd0, 32'h0005_0000},
                         {One, 32'd0}, 1});
        // translation exactly on the right plane
        rows.push_back('{0, 0, 0, 0, 0, 0, 0, 0, {32'd0, One}, {One, 32'd0}, 0});
        // box overlapping the cube with no corner inside, under identity columns
        rows.push_back('{32'hfffb_0000, 32'hfffb_0000, 32'h000a_0000, 32'h000a_0000,
                         {32'd0, One}, 0, {One, 32'd0}, 0,
                         {32'd0, 32'h0005_0000}, {One, 32'd0}, -1});
        // box straddling the cube with no corner inside
        rows.push_back('{32'hfff0_0000, 32'hfff0_0000, 32'h0020_0000, 32'h0020_0000,
                         {32'd0, One}, 0, {One, 32'd0}, 0, 0,
                         {One, 32'd0}, -1});
        // negative width and height
        rows.push_back('{32'h0005_0000, 32'h0005_0000, 32'hfff0_0000, 32'hfff0_0000,
                         {32'd0, One}, 0, {One, 32'd0}, 0,
                         {32'd0, 32'h0003_0000}, {One, 32'd0}, -1});
        // extremes of every field
        rows.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         '1, '1, '1, '1, {2{32'h8000_0000}}, {2{32'h8000_0000}}, -1});
        rows.push_back('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                         {2{32'h7fff_ffff}}, {2{32'h7fff_ffff}}, {2{32'h8000_0000}},
                         {2{32'h8000_0000}}, {2{32'h7fff_ffff}}, {2{32'h7fff_ffff}}, -1});
        rows.push_back('{'1, '1, '1, '1, '1, '1, '1, '1, '1, '1, -1});
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        if (s_axis_tready !== 1'b1) report_mismatch("ready after reset", s_axis_tready, 1'b1);
        foreach (rows[i]) begin
            send_box(pack_box(rows[i]));
            if (rows[i].verdict >= 0 && verdict_q[$] !== rows[i].verdict[0])
                report_mismatch("directed row", verdict_q[$], rows[i].verdict[0]);
        end
        // long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_off = 1'b1;
                repeat (60) @(posedge i_clk);
                hold_off = 1'b0;
            end
            repeat (20) begin
                row = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                        rand_pair(), rand_pair(), rand_pair(), rand_pair(),
                        rand_pair(), rand_pair(), -1};
                send_box(pack_box(row));
            end
        join
        for (int n = 0; n < NumRandom; n++) begin
            if (n % 100 == 0) begin
                send_idle_pct = pcts[(n / 100) % 4][0];
                recv_idle_pct = pcts[(n / 100) % 4][1];
            end
            row = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    rand_pair(), rand_pair(), rand_pair(), rand_pair(),
                    rand_pair(), rand_pair(), -1};
            // mostly near-identity matrices so all decision paths are reached
            if ($urandom_range(3) != 0) begin
                row.c0a = {rand_coord() >>> 4, One + ($urandom_range(0, 65535) - 32768)};
                row.c1a = {One, rand_coord() >>> 4};
                row.c0b = {32'd0, rand_coord()};
                row.c1b = {32'd0, rand_coord()};
                row.c3b = {One, rand_coord()};
            end
            send_box(pack_box(row));
        end
        s_axis_tvalid <= 1'b0;
        recv_idle_pct = 0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (Latency * 4) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("box_clip_space_cull_test_unit_tb: clean");
        end else begin
            $display("box_clip_space_cull_test_unit_tb: errors");
        end
        $finish;
    end

endmodule
